// File: hdl/prq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants for the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int ID_W   = 8;
  localparam int PRI_W  = 8;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t ent;
  } cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic   vld;
    logic   keep;
    entry_t ent;
  } slot_t;

endpackage : prq_pkg
`default_nettype wire

// File: hdl/prq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prq_cell
// One slot of the sorted chain: holds an entry, decides from its own compare
// and its neighbors whether to hold, load the new entry or shift.
// ----------------------------------------------------------------------------
module prq_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  prq_pkg::cmd_t       cmd,
  input  prq_pkg::slot_t      left,
  input  prq_pkg::slot_t      right,
  output prq_pkg::slot_t      slot
);
  import prq_pkg::*;

  logic   vld_r, vld_nxt;
  entry_t ent_r, ent_nxt;
  logic   keep;

  // entries of equal or higher priority stay ahead of the new one
  assign keep = vld_r && (ent_r.pri >= cmd.ent.pri);

  always_comb begin
    vld_nxt = vld_r;
    ent_nxt = ent_r;
    if (cmd.ins && !keep) begin
      if (left.keep) begin
        vld_nxt = 1'b1;
        ent_nxt = cmd.ent;
      end else begin
        // shifting right carries the neighbor's valid bit along
        vld_nxt = left.vld;
        ent_nxt = left.ent;
      end
    end else if (cmd.rem) begin
      vld_nxt = right.vld;
      ent_nxt = right.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign slot.vld  = vld_r;
  assign slot.keep = keep;
  assign slot.ent  = ent_r;

endmodule : prq_cell
`default_nettype wire

// File: hdl/priority_ready_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_ready_queue
// Stable priority queue of process ids built as a chain of sorted cells.
// ----------------------------------------------------------------------------
// Each input transfer inserts an id with its priority or removes the head;
// exactly one result transfer follows per input. Entries sit in a row of
// DEPTH cells in descending priority order, equal priorities first in, first
// out. Every cell compares its priority with the new one in parallel and
// holds, loads or shifts; the queue takes one item per cycle unless held off,
// and the result is in the output register in the cycle after the input
// transfer. The output register is the only buffer: while a result waits
// untaken, input is held off. An insert into a full queue returns status 2,
// a remove on an empty queue status 1; both leave the queue unchanged.
module priority_ready_queue #(
  parameter int DEPTH = prq_pkg::DEPTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // [0] opcode, [8:1] proc_id, [16:9] priority_req, [23:17] zero
  input  wire  [prq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // [7:0] head_id, [9:8] status, [14:10] occupancy, [15] zero
  output logic [prq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import prq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  opcode_t           opcode;
  logic [ID_W-1:0]   proc_id;
  logic [PRI_W-1:0]  priority_req;

  assign opcode       = opcode_t'(in_tdata[0]);
  assign proc_id      = in_tdata[ID_W:1];
  assign priority_req = in_tdata[ID_W+PRI_W:ID_W+1];

  logic             in_xfer;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             full, empty;
  cmd_t             cmd;
  slot_t            slots [DEPTH];

  logic                out_vld_r, out_vld_nxt;
  logic [ID_W-1:0]     head_r, head_nxt;
  status_t             stat_r, stat_nxt;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  assign in_tready = !out_vld_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);

  assign cmd.ins     = in_xfer && (opcode == OP_INSERT) && !full;
  assign cmd.rem     = in_xfer && (opcode == OP_REMOVE) && !empty;
  assign cmd.ent.id  = proc_id;
  assign cmd.ent.pri = priority_req;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t left_s, right_s;
    if (i == 0) begin : g_head
      assign left_s = '{vld: 1'b1, keep: 1'b1, ent: cmd.ent};
    end else begin : g_mid
      assign left_s = slots[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_s = '0;
    end else begin : g_body
      assign right_s = slots[i+1];
    end
    prq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .left  (left_s),
      .right (right_s),
      .slot  (slots[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.rem) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    head_nxt    = head_r;
    stat_nxt    = stat_r;
    if (in_xfer) begin
      out_vld_nxt = 1'b1;
      head_nxt    = '0;
      stat_nxt    = ST_DONE;
      if (opcode == OP_INSERT) begin
        if (full) begin
          stat_nxt = ST_FULL;
        end
      end else if (empty) begin
        stat_nxt = ST_EMPTY;
      end else begin
        head_nxt = slots[0].ent.id;
      end
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    stat_r <= stat_nxt;
  end

  // occupancy in the result is the count after the item, taken to 5 bits
  assign occ_wide   = {{OCC_W{1'b0}}, cnt_r};
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, occ_wide[OCC_W-1:0], stat_r, head_r};

endmodule : priority_ready_queue
`default_nettype wire

// File: tb/tb_priority_ready_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_priority_ready_queue
// Self-checking bench for the stable priority ready queue.
// ----------------------------------------------------------------------------
// A driver streams insert and remove requests from a pending list, and a
// monitor takes the results. Every accepted request is run through a small
// software copy of the sorted queue to get the expected head id, status and
// occupancy, which the monitor compares field by field. Both sides idle at
// random, and the sender now and then holds off until the queue has answered
// everything that it was sent.
module tb_priority_ready_queue;
  import prq_pkg::*;

  localparam int QDEPTH      = DEPTH_DEF;
  localparam int RAND_ITEMS  = 1200;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    bit               pause;
    opcode_t          op;
    logic [ID_W-1:0]  pid;
    logic [PRI_W-1:0] pri;
  } req_t;

  typedef struct {
    logic [ID_W-1:0]  head;
    status_t          st;
    logic [OCC_W-1:0] occ;
  } reply_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  req_t   req_q[$];
  reply_t reply_q[$];

  // software copy of the sorted entries, head at index 0
  logic [ID_W-1:0]  held_id [QDEPTH];
  logic [PRI_W-1:0] held_pri[QDEPTH];
  int               held = 0;

  int errors    = 0;
  int cycles    = 0;
  int src_gap   = 0;
  int snk_stall = 0;
  bit src_calm  = 1'b0;
  bit snk_calm  = 1'b1;

  priority_ready_queue #(.DEPTH(QDEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic reply_t queue_update(opcode_t op, logic [ID_W-1:0] pid,
                                          logic [PRI_W-1:0] pri);
    reply_t r;
    int     pos;
    r.head = '0;
    r.st   = ST_DONE;
    if (op == OP_INSERT) begin
      if (held >= QDEPTH) begin
        r.st = ST_FULL;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < held && held_pri[pos] >= pri) pos++;
        for (int i = held; i > pos; i--) begin
          held_id[i]  = held_id[i-1];
          held_pri[i] = held_pri[i-1];
        end
        held_id[pos]  = pid;
        held_pri[pos] = pri;
        held++;
      end
    end else if (held == 0) begin
      r.st = ST_EMPTY;
    end else begin
      r.head = held_id[0];
      for (int i = 1; i < held; i++) begin
        held_id[i-1]  = held_id[i];
        held_pri[i-1] = held_pri[i];
      end
      held--;
    end
    r.occ = OCC_W'(held);
    return r;
  endfunction

  // idle cycles before the next transfer; calm stretches run back to back
  function automatic int idle_draw(bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // driver
  always @(posedge clk) begin
    req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      src_gap   <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (src_gap > 0) begin
        in_tvalid <= 1'b0;
        src_gap   <= src_gap - 1;
      end else if (req_q.size() != 0 && req_q[0].pause) begin
        in_tvalid <= 1'b0;
        // hold off until every result sent so far has come back
        if (!in_tvalid && reply_q.size() == 0) void'(req_q.pop_front());
      end else if (req_q.size() != 0) begin
        nxt = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {7'b0, nxt.pri, nxt.pid, nxt.op};
        if ($urandom_range(0, 24) == 0) src_calm <= ~src_calm;
        src_gap   <= idle_draw(src_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: predicts on each input transfer, checks each output transfer
  always @(posedge clk) begin
    reply_t want;
    int     nstall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      snk_stall  <= 0;
    end else begin
      if (in_tvalid && in_tready)
        reply_q.push_back(queue_update(opcode_t'(in_tdata[0]), in_tdata[8:1],
                                       in_tdata[16:9]));
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          $error("result with nothing expected: tdata %h", out_tdata);
          errors++;
        end else begin
          want = reply_q.pop_front();
          if (out_tdata[7:0] !== want.head) begin
            $error("head_id: expected %0d, got %0d", want.head, out_tdata[7:0]);
            errors++;
          end
          if (out_tdata[9:8] !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, out_tdata[9:8]);
            errors++;
          end
          if (out_tdata[14:10] !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, out_tdata[14:10]);
            errors++;
          end
        end
        if ($urandom_range(0, 24) == 0) snk_calm <= ~snk_calm;
        nstall = idle_draw(snk_calm);
      end else begin
        nstall = (snk_stall > 0) ? snk_stall - 1 : 0;
      end
      snk_stall  <= nstall;
      out_tready <= (nstall == 0);
    end
  end

  task automatic add_req(opcode_t op, int pid, int pri);
    req_t r;
    r.pause = 1'b0;
    r.op    = op;
    r.pid   = ID_W'(pid);
    r.pri   = PRI_W'(pri);
    req_q.push_back(r);
  endtask

  task automatic add_pause();
    req_t r;
    r.pause = 1'b1;
    r.op    = OP_INSERT;
    r.pid   = '0;
    r.pri   = '0;
    req_q.push_back(r);
  endtask

  initial begin
    int made;
    int burst;
    int ins_pct;
    int pri_top;
    int next_pause;

    // remove on an empty queue
    add_req(OP_REMOVE, 8'hFF, 8'hFF);
    // fill up: extremes of id and priority, runs of equal priority
    add_req(OP_INSERT, 8'h00, 8'h00);
    add_req(OP_INSERT, 8'hFF, 8'hFF);
    add_req(OP_INSERT, 8'h11, 8'h80);
    add_req(OP_INSERT, 8'h22, 8'h80);
    add_req(OP_INSERT, 8'h33, 8'h80);
    add_req(OP_INSERT, 8'h44, 8'hFF);
    add_req(OP_INSERT, 8'h55, 8'h00);
    add_req(OP_INSERT, 8'hAA, 8'h7F);
    add_req(OP_INSERT, 8'h01, 8'h01);
    add_req(OP_INSERT, 8'h80, 8'hFE);
    add_req(OP_INSERT, 8'h66, 8'h80);
    add_req(OP_INSERT, 8'h77, 8'h01);
    add_req(OP_INSERT, 8'h88, 8'h00);
    add_req(OP_INSERT, 8'h99, 8'hC3);
    add_req(OP_INSERT, 8'hFE, 8'h3C);
    add_req(OP_INSERT, 8'h7F, 8'h80);
    // insert on a full queue
    add_req(OP_INSERT, 8'h5A, 8'hFF);
    add_req(OP_REMOVE, 8'h00, 8'h00);
    add_req(OP_REMOVE, 8'hA5, 8'h5A);
    add_req(OP_REMOVE, 8'h5A, 8'hA5);
    add_req(OP_REMOVE, 8'hFF, 8'h00);
    add_pause();

    // random bursts that each lean toward inserts, removes or neither, pushing the queue toward full or empty
    made       = 0;
    next_pause = 300;
    while (made < RAND_ITEMS) begin
      burst = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 15;
      endcase
      case ($urandom_range(0, 2))
        0: pri_top = 3;
        1: pri_top = 15;
        default: pri_top = 255;
      endcase
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 99) < ins_pct)
          add_req(OP_INSERT, $urandom_range(0, 255), $urandom_range(0, pri_top));
        else
          add_req(OP_REMOVE, $urandom_range(0, 255), $urandom_range(0, 255));
      end
      made += burst;
      if (made >= next_pause) begin
        add_pause();
        next_pause += 300;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0) @(posedge clk);
    // the driver registers in_tvalid, so wait for the last request to reach the bus
    @(posedge clk);
    while (in_tvalid) @(posedge clk);
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule : tb_priority_ready_queue
`default_nettype wire

// File: sim.f
hdl/prq_pkg.sv
hdl/prq_cell.sv
hdl/priority_ready_queue.sv
tb/tb_priority_ready_queue.sv
